### rtl/fbpa_pkg.sv
`default_nettype none

package fbpa_pkg;

   typedef enum logic [1:0] {
      MODE_ALLOC  = 2'd0,
      MODE_ZALLOC = 2'd1,
      MODE_FREE   = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_OK            = 3'd0,
      ST_TOO_LARGE     = 3'd1,
      ST_OUT_OF_MEMORY = 3'd2,
      ST_NULL_POINTER  = 3'd3,
      ST_NOT_ALLOCATED = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      CMD_ALLOC,
      CMD_FREE,
      CMD_REPLY
   } cmd_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] request_size;
      logic [31:0] element_count;
      logic [31:0] release_address;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] block_address;
      logic [7:0]  clear_bytes;
   } rsp_type;

   typedef struct packed {
      cmd_type    cmd;
      status_type status;
      logic [7:0] clear_bytes;
   } entry_type;

   localparam int unsigned QUEUE_DEPTH = 2;

   localparam logic [1:0] REG_POOL_BASE = 2'd0;

endpackage

`default_nettype wire

### rtl/fbpa_front.sv
`default_nettype none

module fbpa_front
   import fbpa_pkg::*;
#(
   parameter int unsigned NUM_BLOCKS   = 60,
   parameter int unsigned BLOCK_BYTES  = 192,
   parameter int unsigned BLOCK_STRIDE = 224
) (
   input  var req_type                 req_data,
   input  var logic [31:0]             pool_base,
   output entry_type                   entry,
   output logic      [NUM_BLOCKS-1:0]  match
);

   localparam logic [63:0] LIMIT = 64'(BLOCK_BYTES);

   logic [63:0] product;
   logic [31:0] offset;

   assign product = 64'(req_data.element_count) * 64'(req_data.request_size);
   assign offset  = req_data.release_address - pool_base;

   // The block whose start lies at the given address, if any.
   for (genvar i = 0; i < NUM_BLOCKS; i++) begin : g_match
      localparam logic [31:0] START = 32'(i * BLOCK_STRIDE);
      assign match[i] = (offset == START);
   end

   always_comb begin
      entry.cmd         = CMD_REPLY;
      entry.status      = ST_OK;
      entry.clear_bytes = 8'd0;
      unique case (mode_type'(req_data.mode))
         MODE_ALLOC: begin
            if (64'(req_data.request_size) > LIMIT) begin
               entry.status = ST_TOO_LARGE;
            end else begin
               entry.cmd = CMD_ALLOC;
            end
         end
         MODE_ZALLOC: begin
            if (product > LIMIT) begin
               entry.status = ST_TOO_LARGE;
            end else begin
               entry.cmd         = CMD_ALLOC;
               entry.clear_bytes = product[7:0];
            end
         end
         MODE_FREE: begin
            if (req_data.release_address == 32'd0) begin
               entry.status = ST_NULL_POINTER;
            end else begin
               entry.cmd = CMD_FREE;
            end
         end
         MODE_NONE: begin
            entry.status = ST_OK;
         end
         default: begin
            entry.status = ST_OK;
         end
      endcase
   end

endmodule

`default_nettype wire

### rtl/fbpa_queue.sv
`default_nettype none

module fbpa_queue
   import fbpa_pkg::*;
#(
   parameter int unsigned DATA_W = 8
) (
   input  var logic              clock,
   input  var logic              reset,
   input  var logic              push,
   input  var logic [DATA_W-1:0] push_data,
   output logic                  full,
   input  var logic              pop,
   output logic                  not_empty,
   output logic [DATA_W-1:0]     pop_data
);

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

   logic [DATA_W-1:0] slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full      = (count_ff == DEPTH_CNT);
   assign not_empty = (count_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      priority if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### rtl/fbpa_back.sv
`default_nettype none

module fbpa_back
   import fbpa_pkg::*;
#(
   parameter int unsigned NUM_BLOCKS   = 60,
   parameter int unsigned BLOCK_STRIDE = 224
) (
   input  var logic                   clock,
   input  var logic                   reset,
   input  var logic                   q_not_empty,
   input  var entry_type              entry,
   input  var logic [NUM_BLOCKS-1:0]  match,
   output logic                       pop,
   input  var logic [31:0]            pool_base,
   output logic                       rsp_valid,
   input  var logic                   rsp_stall,
   output rsp_type                    rsp_data
);

   logic [NUM_BLOCKS-1:0] used_ff, used_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic [NUM_BLOCKS-1:0] free_map;
   logic [NUM_BLOCKS-1:0] lowest_free;
   logic [NUM_BLOCKS-1:0] hit;
   logic [31:0]           start_offset;

   assign pop = q_not_empty && (!rsp_valid_ff || !rsp_stall);

   // Isolate the lowest free block as a one-hot vector.
   assign free_map    = ~used_ff;
   assign lowest_free = free_map & (~free_map + NUM_BLOCKS'(1));
   assign hit         = match & used_ff;

   always_comb begin
      start_offset = '0;
      for (int i = 0; i < NUM_BLOCKS; i++) begin
         if (lowest_free[i]) begin
            start_offset = start_offset | 32'(i * BLOCK_STRIDE);
         end
      end
   end

   always_comb begin
      used_in                   = used_ff;
      rsp_data_in.status        = ST_OK;
      rsp_data_in.block_address = '0;
      rsp_data_in.clear_bytes   = '0;
      unique case (entry.cmd)
         CMD_ALLOC: begin
            if (|free_map) begin
               used_in                   = used_ff | lowest_free;
               rsp_data_in.block_address = pool_base + start_offset;
               rsp_data_in.clear_bytes   = entry.clear_bytes;
            end else begin
               rsp_data_in.status = ST_OUT_OF_MEMORY;
            end
         end
         CMD_FREE: begin
            if (|hit) begin
               used_in = used_ff & ~hit;
            end else begin
               rsp_data_in.status = ST_NOT_ALLOCATED;
            end
         end
         CMD_REPLY: begin
            rsp_data_in.status = entry.status;
         end
         default: begin
            rsp_data_in.status = entry.status;
         end
      endcase
   end

   always_comb begin
      priority if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            used_ff <= used_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

### rtl/fixed_block_pool_allocator.sv
`default_nettype none

// Fixed-size block pool allocator. Each request item (allocate, zero-filled
// allocate, free or none) gives exactly one response item, in order. The front
// end checks sizes and decodes a freed address into its block, a two-entry
// queue follows, and the back end searches and updates the used bitmap and
// holds the response in an output register. One item is taken every cycle
// while the response side keeps up; a response becomes valid once its request
// has been written into the queue and read from it straight into the output
// register. pool_base_address is at byte address 0 and may be written only
// while no item is in flight.
module fixed_block_pool_allocator
   import fbpa_pkg::*;
#(
   parameter int unsigned NUM_BLOCKS   = 60,
   parameter int unsigned BLOCK_BYTES  = 192,
   parameter int unsigned BLOCK_STRIDE = 224
) (
   input  var logic                   clock,
   input  var logic                   reset,
   input  var logic                   req_valid,
   output logic                       req_stall,
   input  var req_type                req_data,
   output logic                       rsp_valid,
   input  var logic                   rsp_stall,
   output rsp_type                    rsp_data,
   input  var logic                   psel,
   input  var logic                   penable,
   input  var logic                   pwrite,
   input  var logic [1:0]             paddr,
   input  var logic [31:0]            pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);

   localparam int unsigned ENTRY_W = $bits(entry_type) + NUM_BLOCKS;

   logic [31:0]           pool_base_ff, pool_base_in;
   logic                  csr_write;
   entry_type             push_entry, pop_entry;
   logic [NUM_BLOCKS-1:0] push_match, pop_match;
   logic                  q_full, q_not_empty, q_push, q_pop;
   logic                  reg_hit;

   assign pready    = 1'b1;
   assign reg_hit   = (paddr == REG_POOL_BASE);
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = reg_hit ? pool_base_ff : 32'd0;

   always_comb begin
      pool_base_in = pool_base_ff;
      if (csr_write && reg_hit) begin
         pool_base_in = pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_base_ff <= '0;
      end else begin
         pool_base_ff <= pool_base_in;
      end
   end

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   fbpa_front #(
      .NUM_BLOCKS   (NUM_BLOCKS),
      .BLOCK_BYTES  (BLOCK_BYTES),
      .BLOCK_STRIDE (BLOCK_STRIDE)
   ) u_front (
      .req_data  (req_data),
      .pool_base (pool_base_ff),
      .entry     (push_entry),
      .match     (push_match)
   );

   fbpa_queue #(
      .DATA_W (ENTRY_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({push_entry, push_match}),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_data  ({pop_entry, pop_match})
   );

   fbpa_back #(
      .NUM_BLOCKS   (NUM_BLOCKS),
      .BLOCK_STRIDE (BLOCK_STRIDE)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .entry       (pop_entry),
      .match       (pop_match),
      .pop         (q_pop),
      .pool_base   (pool_base_ff),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

`default_nettype wire
